/* hw/rtl/ppa_pkg.sv */
package ppa_pkg;

    // defaults for the top-level parameters
    localparam int MAX_VERTICES_DEF = 256;
    localparam int COORD_WIDTH_DEF  = 16;

    // result field widths
    localparam int LEN_W   = 25;
    localparam int AREA_W  = 40;
    localparam int CROSS_W = 41;
    localparam int TOTAL_W = 9;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam logic signed [CROSS_W-1:0] CROSS_MAX = {1'b0, {(CROSS_W-1){1'b1}}};
    localparam logic signed [CROSS_W-1:0] CROSS_MIN = {1'b1, {(CROSS_W-1){1'b0}}};
    localparam logic signed [AREA_W-1:0]  AREA_MAX  = {1'b0, {(AREA_W-1){1'b1}}};
    localparam logic signed [AREA_W-1:0]  AREA_MIN  = {1'b1, {(AREA_W-1){1'b0}}};

    // sequencer of the top level
    typedef enum logic [1:0] {
        S_IDLE,
        S_EDGE,
        S_OUT
    } ppa_state_t;

    // sequencer of the edge unit
    typedef enum logic [2:0] {
        E_IDLE,
        E_MUL,
        E_SAT,
        E_ROOT,
        E_DONE
    } edge_state_t;

endpackage

/* hw/rtl/ppa_edge.sv */
// One polygon edge: serial dx^2+dy^2 and cross product, then a
// bit-serial floor square root. Operands must hold from start to done.
module ppa_edge import ppa_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int CW  = COORD_WIDTH,
    localparam int SQW = 2 * CW + 1,
    localparam int SW  = (SQW > 64) ? 64 : SQW,
    localparam int RW  = (SW + 1) / 2
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [CW-1:0]      x0,
    input  logic signed [CW-1:0]      y0,
    input  logic signed [CW-1:0]      x1,
    input  logic signed [CW-1:0]      y1,
    output logic                      done,
    output logic [RW-1:0]             edge_len,
    output logic signed [CROSS_W-1:0] cross_term
);

    localparam int NW  = 2 * RW;
    localparam int PW  = 2 * CW + 2;
    localparam int XW  = (PW > CROSS_W) ? PW : CROSS_W;
    localparam int STW = $clog2(CW + 2);

    localparam logic signed [XW-1:0] TERM_MAX = XW'(CROSS_MAX);
    localparam logic signed [XW-1:0] TERM_MIN = XW'(CROSS_MIN);

    edge_state_t state_reg, state_next;
    logic [STW-1:0] step_reg, step_next;

    // squares: multiplicands, shifting multipliers, split product
    logic [CW-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [CW-1:0] mx_reg, mx_next, my_reg, my_next;
    logic [CW:0]   sqh_reg, sqh_next;
    logic [CW-1:0] sql_reg, sql_next;

    // cross product: x0*y1 - y0*x1
    logic signed [CW-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic [CW-1:0]        by_reg, by_next, bx_reg, bx_next;
    logic signed [CW+1:0] ph_reg, ph_next;
    logic [CW-1:0]        pl_reg, pl_next;

    // root
    logic [NW-1:0]   n_reg, n_next;
    logic [RW+1:0]   rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic signed [CROSS_W-1:0] term_reg, term_next;

    // combinational helpers
    logic signed [CW:0]   diff_x, diff_y;
    logic [CW-1:0]        abs_x, abs_y;
    logic [CW+1:0]        sq_t;
    logic signed [CW+2:0] p_t, p_a1, p_a2;
    logic                 last_bit;
    logic [SQW:0]         sq_ext;
    logic [SW-1:0]        sq_sat;
    logic signed [PW-1:0] prod;
    logic signed [XW-1:0] prod_x;
    logic [RW+1:0]        rem_sh, trial;

    assign diff_x = {x0[CW-1], x0} - {x1[CW-1], x1};
    assign diff_y = {y0[CW-1], y0} - {y1[CW-1], y1};
    assign abs_x  = diff_x[CW] ? CW'(-diff_x) : diff_x[CW-1:0];
    assign abs_y  = diff_y[CW] ? CW'(-diff_y) : diff_y[CW-1:0];

    assign last_bit = (step_reg == STW'(CW - 1));

    // square step: add both multiplicands under their low multiplier bits
    assign sq_t = (CW+2)'(sqh_reg)
                + (mx_reg[0] ? (CW+2)'(dx_reg) : '0)
                + (my_reg[0] ? (CW+2)'(dy_reg) : '0);

    // signed product step: the sign bit of the multiplier weighs negative
    always_comb begin
        p_a1 = by_reg[0] ? (CW+3)'(ax_reg) : '0;
        p_a2 = bx_reg[0] ? (CW+3)'(ay_reg) : '0;
        if (last_bit) begin
            p_a1 = -p_a1;
            p_a2 = -p_a2;
        end
        p_t = (CW+3)'(ph_reg) + p_a1 - p_a2;
    end

    assign sq_ext = {1'b0, sqh_reg, sql_reg};
    assign sq_sat = ((sq_ext >> SW) != '0) ? {SW{1'b1}} : sq_ext[SW-1:0];
    assign prod   = {ph_reg, pl_reg};
    assign prod_x = XW'(prod);

    assign rem_sh = {rem_reg[RW-1:0], n_reg[NW-1:NW-2]};
    assign trial  = {root_reg, 2'b01};

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        sqh_next   = sqh_reg;
        sql_next   = sql_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        ph_next    = ph_reg;
        pl_next    = pl_reg;
        n_next     = n_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        term_next  = term_reg;
        unique case (state_reg)
            E_IDLE: begin
                if (start) begin
                    dx_next    = abs_x;
                    dy_next    = abs_y;
                    mx_next    = abs_x;
                    my_next    = abs_y;
                    sqh_next   = '0;
                    ax_next    = x0;
                    ay_next    = y0;
                    bx_next    = x1;
                    by_next    = y1;
                    ph_next    = '0;
                    step_next  = '0;
                    state_next = E_MUL;
                end
            end
            E_MUL: begin
                sqh_next  = sq_t[CW+1:1];
                sql_next  = {sq_t[0], sql_reg[CW-1:1]};
                mx_next   = mx_reg >> 1;
                my_next   = my_reg >> 1;
                ph_next   = p_t[CW+2:1];
                pl_next   = {p_t[0], pl_reg[CW-1:1]};
                bx_next   = bx_reg >> 1;
                by_next   = by_reg >> 1;
                step_next = step_reg + 1'b1;
                if (last_bit) begin
                    state_next = E_SAT;
                end
            end
            E_SAT: begin
                n_next    = NW'(sq_sat);
                rem_next  = '0;
                root_next = '0;
                step_next = '0;
                if (prod_x > TERM_MAX) begin
                    term_next = CROSS_MAX;
                end else if (prod_x < TERM_MIN) begin
                    term_next = CROSS_MIN;
                end else begin
                    term_next = prod_x[CROSS_W-1:0];
                end
                state_next = E_ROOT;
            end
            E_ROOT: begin
                n_next = n_reg << 2;
                if (rem_sh >= trial) begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[RW-2:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[RW-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STW'(RW - 1)) begin
                    state_next = E_DONE;
                end
            end
            E_DONE: begin
                state_next = E_IDLE;
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
        end else begin
            state_reg <= state_next;
        end
        step_reg <= step_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        sqh_reg  <= sqh_next;
        sql_reg  <= sql_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        ph_reg   <= ph_next;
        pl_reg   <= pl_next;
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        term_reg <= term_next;
    end

    assign done       = (state_reg == E_DONE);
    assign edge_len   = root_reg;
    assign cross_term = term_reg;

endmodule

/* hw/rtl/polygon_perimeter_and_area.sv */
// Polygon perimeter and shoelace area.
// Input channel s_*: one vertex per transfer, x and y as signed Q8.8 in
// s_tdata, s_tlast set on the final vertex of a polygon.
// Output channel m_*: one transfer per polygon, after its final vertex:
// perimeter (unsigned Q17.8, zero for fewer than three vertices), signed area
// (shoelace cross sum, saturated to 40 bits), vertex count, and in m_tuser
// a flag for vertices dropped past MAX_VERTICES.
// Every edge runs through one shared serial unit: shift-and-add for
// dx^2+dy^2 and the cross product, then a bit-serial square root
// (RW = 17 result bits at 16-bit coordinates). While an edge runs s_tready
// stays low, so no new vertex is taken before the last one's edge is done.
// The final vertex also runs the closing edge, so m_tvalid rises only
// once the closing edge is done too; the first vertex of a polygon and
// dropped vertices without s_tlast start no edge and leave s_tready high.
// A finished result sits in an output register; new vertices are taken
// while it waits. Only when a second result is ready before the first is
// taken does the block hold s_tready low until m_tready frees the register.
// Reset (aresetn low, synchronous) clears all polygon state and drops any
// result not yet transferred.
module polygon_perimeter_and_area import ppa_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    localparam int CW       = COORD_WIDTH,
    localparam int S_DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    // vertex channel
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // x_coord, y_coord, zero fill
    input  logic                s_tlast,   // final_vertex
    // result channel
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [79:0]         m_tdata,   // perimeter, signed_area, vertex_total, zero fill
    output logic                m_tuser    // too_many
);

    localparam int SQW   = 2 * CW + 1;
    localparam int SW    = (SQW > 64) ? 64 : SQW;
    localparam int RW    = (SW + 1) / 2;
    localparam int LSW   = ((RW > LEN_W) ? RW : LEN_W) + 1;
    localparam int ACC_W = CROSS_W + 1;
    localparam int VCW   = $clog2(MAX_VERTICES + 1);
    localparam int OUT_W = LEN_W + AREA_W + TOTAL_W;

    localparam logic signed [ACC_W-1:0]   ACC_MAX  = ACC_W'(CROSS_MAX);
    localparam logic signed [ACC_W-1:0]   ACC_MIN  = ACC_W'(CROSS_MIN);
    localparam logic signed [CROSS_W-1:0] AREA_HI  = CROSS_W'(AREA_MAX);
    localparam logic signed [CROSS_W-1:0] AREA_LO  = CROSS_W'(AREA_MIN);

    ppa_state_t state_reg, state_next;

    logic signed [CW-1:0] first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic signed [CW-1:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic [VCW-1:0]       count_reg, count_next;
    logic [LEN_W-1:0]     len_sum_reg, len_sum_next;
    logic signed [CROSS_W-1:0] cross_sum_reg, cross_sum_next;
    logic                 dropped_reg, dropped_next;
    logic                 fin_reg, fin_next;
    logic                 closing_reg, closing_next;
    logic                 start_reg, start_next;

    // edge operands, held while the edge unit works
    logic signed [CW-1:0] ex0_reg, ex0_next, ey0_reg, ey0_next;
    logic signed [CW-1:0] ex1_reg, ex1_next, ey1_reg, ey1_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [79:0]       m_tdata_reg, m_tdata_next;
    logic              m_tuser_reg, m_tuser_next;

    logic                      edge_done;
    logic [RW-1:0]             edge_len;
    logic signed [CROSS_W-1:0] edge_term;

    logic signed [CW-1:0]      in_x, in_y;
    logic                      s_fire;
    logic [LSW-1:0]            len_tot;
    logic signed [ACC_W-1:0]   cross_tot;
    logic [LEN_W-1:0]          perim_out;
    logic signed [AREA_W-1:0]  area_out;

    ppa_edge #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_edge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start_reg),
        .x0         (ex0_reg),
        .y0         (ey0_reg),
        .x1         (ex1_reg),
        .y1         (ey1_reg),
        .done       (edge_done),
        .edge_len   (edge_len),
        .cross_term (edge_term)
    );

    assign in_x     = s_tdata[CW-1:0];
    assign in_y     = s_tdata[2*CW-1:CW];
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // accumulators, both saturating
    assign len_tot   = LSW'(len_sum_reg) + LSW'(edge_len);
    assign cross_tot = ACC_W'(cross_sum_reg) + ACC_W'(edge_term);

    // result fields
    assign perim_out = (count_reg > VCW'(2)) ? len_sum_reg : '0;
    always_comb begin
        if (cross_sum_reg > AREA_HI) begin
            area_out = AREA_MAX;
        end else if (cross_sum_reg < AREA_LO) begin
            area_out = AREA_MIN;
        end else begin
            area_out = cross_sum_reg[AREA_W-1:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        first_x_next   = first_x_reg;
        first_y_next   = first_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        count_next     = count_reg;
        len_sum_next   = len_sum_reg;
        cross_sum_next = cross_sum_reg;
        dropped_next   = dropped_reg;
        fin_next       = fin_reg;
        closing_next   = closing_reg;
        start_next     = 1'b0;
        ex0_next       = ex0_reg;
        ey0_next       = ey0_reg;
        ex1_next       = ex1_reg;
        ey1_next       = ey1_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    fin_next     = s_tlast;
                    closing_next = 1'b0;
                    if (count_reg < VCW'(MAX_VERTICES)) begin
                        prev_x_next = in_x;
                        prev_y_next = in_y;
                        count_next  = count_reg + 1'b1;
                        if (count_reg == '0) begin
                            first_x_next = in_x;
                            first_y_next = in_y;
                            if (s_tlast) begin
                                // single vertex: closing edge onto itself
                                ex0_next     = in_x;
                                ey0_next     = in_y;
                                ex1_next     = in_x;
                                ey1_next     = in_y;
                                closing_next = 1'b1;
                                start_next   = 1'b1;
                                state_next   = S_EDGE;
                            end
                        end else begin
                            ex0_next   = prev_x_reg;
                            ey0_next   = prev_y_reg;
                            ex1_next   = in_x;
                            ey1_next   = in_y;
                            start_next = 1'b1;
                            state_next = S_EDGE;
                        end
                    end else begin
                        // vertex past the limit: drop it, still close on tlast
                        dropped_next = 1'b1;
                        if (s_tlast) begin
                            if (count_reg != '0) begin
                                ex0_next     = prev_x_reg;
                                ey0_next     = prev_y_reg;
                                ex1_next     = first_x_reg;
                                ey1_next     = first_y_reg;
                                closing_next = 1'b1;
                                start_next   = 1'b1;
                                state_next   = S_EDGE;
                            end else begin
                                state_next = S_OUT;
                            end
                        end
                    end
                end
            end
            S_EDGE: begin
                if (edge_done) begin
                    len_sum_next = (len_tot > LSW'(LEN_MAX)) ? LEN_MAX
                                                            : len_tot[LEN_W-1:0];
                    if (cross_tot > ACC_MAX) begin
                        cross_sum_next = CROSS_MAX;
                    end else if (cross_tot < ACC_MIN) begin
                        cross_sum_next = CROSS_MIN;
                    end else begin
                        cross_sum_next = cross_tot[CROSS_W-1:0];
                    end
                    priority if (fin_reg && !closing_reg) begin
                        // last vertex back to the first one
                        ex0_next     = prev_x_reg;
                        ey0_next     = prev_y_reg;
                        ex1_next     = first_x_reg;
                        ey1_next     = first_y_reg;
                        closing_next = 1'b1;
                        start_next   = 1'b1;
                    end else if (fin_reg) begin
                        state_next = S_OUT;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next  = 1'b1;
                    m_tdata_next   = {(80 - OUT_W)'(0), TOTAL_W'(count_reg),
                                      area_out, perim_out};
                    m_tuser_next   = dropped_reg;
                    first_x_next   = '0;
                    first_y_next   = '0;
                    prev_x_next    = '0;
                    prev_y_next    = '0;
                    count_next     = '0;
                    len_sum_next   = '0;
                    cross_sum_next = '0;
                    dropped_next   = 1'b0;
                    fin_next       = 1'b0;
                    closing_next   = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            count_reg     <= '0;
            len_sum_reg   <= '0;
            cross_sum_reg <= '0;
            dropped_reg   <= 1'b0;
            fin_reg       <= 1'b0;
            closing_reg   <= 1'b0;
            start_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            first_x_reg   <= first_x_next;
            first_y_reg   <= first_y_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            count_reg     <= count_next;
            len_sum_reg   <= len_sum_next;
            cross_sum_reg <= cross_sum_next;
            dropped_reg   <= dropped_next;
            fin_reg       <= fin_next;
            closing_reg   <= closing_next;
            start_reg     <= start_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        ex0_reg     <= ex0_next;
        ey0_reg     <= ey0_next;
        ex1_reg     <= ex1_next;
        ey1_reg     <= ey1_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* dv/polygon_checker.sv */
module polygon_checker import ppa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // x_coord, y_coord
    input  logic        s_tlast,   // final_vertex
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,   // perimeter, signed_area, vertex_total, zero fill
    input  logic        m_tuser,   // too_many
    output int          errors,
    output int          awaited,
    output int          checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AREA_LO  = LEN_W;
    localparam int TOTAL_LO = LEN_W + AREA_W;
    localparam int FILL_LO  = TOTAL_LO + TOTAL_W;

    typedef struct {
        logic [LEN_W-1:0]         perimeter;
        logic signed [AREA_W-1:0] area;
        logic [TOTAL_W-1:0]       total;
        logic                     too_many;
    } poly_result_t;

    poly_result_t polygon_results_q[$];

    // running state of the polygon being received
    logic signed [15:0] first_x, first_y, last_x, last_y;
    int                 vertex_cnt;
    logic [LEN_W-1:0]   length_acc;
    longint             cross_acc;
    logic               dropped;

    int err_cnt = 0;
    int chk_cnt = 0;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // floor square root, one result bit per step from the top
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root, trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    task automatic clear_polygon();
        first_x    = '0;
        first_y    = '0;
        last_x     = '0;
        last_y     = '0;
        vertex_cnt = 0;
        length_acc = '0;
        cross_acc  = 0;
        dropped    = 1'b0;
    endtask

    // edge length into the perimeter, cross product into the shoelace sum
    task automatic add_edge_terms(input logic signed [15:0] xa, input logic signed [15:0] ya,
                                  input logic signed [15:0] xb, input logic signed [15:0] yb);
        longint          dx, dy, term;
        longint unsigned len_sum;
        dx = longint'(xa) - longint'(xb);
        dy = longint'(ya) - longint'(yb);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        len_sum = longint'(length_acc) + floor_sqrt(dx * dx + dy * dy);
        length_acc = (len_sum > LEN_MAX) ? LEN_MAX : len_sum[LEN_W-1:0];
        term = longint'(xa) * longint'(yb) - longint'(ya) * longint'(xb);
        term = clamp(term, longint'(CROSS_MIN), longint'(CROSS_MAX));
        cross_acc = clamp(cross_acc + term, longint'(CROSS_MIN), longint'(CROSS_MAX));
    endtask

    task automatic take_vertex(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic fin);
        poly_result_t res;
        if (vertex_cnt < MAX_VERTICES_DEF) begin
            if (vertex_cnt == 0) begin
                first_x = x;
                first_y = y;
            end else begin
                add_edge_terms(last_x, last_y, x, y);
            end
            last_x = x;
            last_y = y;
            vertex_cnt++;
        end else begin
            dropped = 1'b1;
        end
        if (fin) begin
            if (vertex_cnt > 0)
                add_edge_terms(last_x, last_y, first_x, first_y);
            res.perimeter = (vertex_cnt > 2) ? length_acc : '0;
            res.area      = AREA_W'(clamp(cross_acc, longint'(AREA_MIN), longint'(AREA_MAX)));
            res.total     = TOTAL_W'(vertex_cnt);
            res.too_many  = dropped;
            polygon_results_q.push_back(res);
            clear_polygon();
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        if (err_cnt < 40)
            $display("%0t ns: result %0d: %s is %0d, expected %0d", $time, chk_cnt, what, got,
                     want);
        err_cnt++;
    endtask

    task automatic check_result();
        poly_result_t             want;
        logic signed [AREA_W-1:0] got_area;
        got_area = m_tdata[TOTAL_LO-1:AREA_LO];
        if (polygon_results_q.size() == 0) begin
            report_mismatch("unexpected result, perimeter", longint'(m_tdata[LEN_W-1:0]),
                            64'sd0);
        end else begin
            want = polygon_results_q.pop_front();
            if (m_tdata[LEN_W-1:0] !== want.perimeter)
                report_mismatch("perimeter", longint'(m_tdata[LEN_W-1:0]),
                                longint'(want.perimeter));
            if (got_area !== want.area)
                report_mismatch("signed_area", longint'(got_area), longint'(want.area));
            if (m_tdata[FILL_LO-1:TOTAL_LO] !== want.total)
                report_mismatch("vertex_total", longint'(m_tdata[FILL_LO-1:TOTAL_LO]),
                                longint'(want.total));
            if (m_tdata[79:FILL_LO] !== '0)
                report_mismatch("zero fill", longint'(m_tdata[79:FILL_LO]), 64'sd0);
            if (m_tuser !== want.too_many)
                report_mismatch("too_many", longint'(m_tuser), longint'(want.too_many));
        end
        chk_cnt++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_polygon();
            polygon_results_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                take_vertex(s_tdata[15:0], s_tdata[31:16], s_tlast);
            if (m_tvalid && m_tready)
                check_result();
        end
        errors  <= err_cnt;
        awaited <= polygon_results_q.size();
        checked <= chk_cnt;
    end

endmodule

/* dv/testbench.sv */
module testbench import ppa_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // random part of the run; the directed polygons add about 535 more
    localparam int RANDOM_VERTICES = 415;

    // how spread out the coordinates of one polygon are
    typedef enum int {
        SPREAD_FULL,    // anywhere in the Q8.8 range
        SPREAD_NEAR,    // within +-8.0 of the origin
        SPREAD_EDGES    // range limits and values next to zero
    } coord_spread_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // x_coord, y_coord
    logic        s_tlast;    // final_vertex
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;    // perimeter, signed_area, vertex_total, zero fill
    logic        m_tuser;    // too_many

    int errors, awaited, checked;

    // burst flags switch off the random gaps on one side for a polygon
    logic tx_burst = 1'b0;
    logic rx_burst = 1'b0;

    int sent_vertices = 0;
    int polygons      = 0;
    int overlong      = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    polygon_perimeter_and_area dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // predicts every polygon result and compares the result channel
    polygon_checker watch (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .awaited  (awaited),
        .checked  (checked)
    );

    // One vertex transfer. A random gap drops tvalid first; with no gap tvalid
    // stays high straight into the next transfer.
    task automatic send_vertex(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic fin);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        sent_vertices++;
        if (fin)
            polygons++;
    endtask

    // Walk n corners of the full-range square in turn; the last
    // vertex carries tlast. Past MAX_VERTICES the rest are dropped.
    task automatic send_square(input int n, input logic clockwise);
        logic signed [15:0] cx [4] = '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000};
        logic signed [15:0] cy [4] = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff};
        int k;
        for (int i = 0; i < n; i++) begin
            k = clockwise ? 3 - (i % 4) : i % 4;
            send_vertex(cx[k], cy[k], i == n - 1);
        end
        if (n > MAX_VERTICES_DEF)
            overlong++;
    endtask

    // Hold the sender until every predicted result has gone out. The count
    // from the checker is registered and trails, hence the edge before the test.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited != 0);
    endtask

    function automatic logic signed [15:0] rand_coord(coord_spread_t spread);
        case (spread)
            SPREAD_NEAR: begin
                return 16'($urandom_range(0, 4095)) - 16'sd2048;
            end
            SPREAD_EDGES: begin
                case ($urandom_range(0, 4))
                    0:       return 16'sh8000;
                    1:       return 16'sh7fff;
                    2:       return 16'sh0000;
                    3:       return 16'shffff;
                    default: return 16'sh0001;
                endcase
            end
            default: begin
                return 16'($urandom);
            end
        endcase
    endfunction

    // Result side: stall for a random count per transfer, then hold tready
    // until the transfer happens.
    initial begin
        int stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Stimulus and verdict
    initial begin
        int            n, pick, random_sent;
        coord_spread_t spread;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // lone vertex: no perimeter, closing edge onto itself
        send_vertex(16'sh7fff, 16'sh8000, 1'b1);
        // two vertices: perimeter stays zero, cross terms cancel
        send_vertex(16'sh8000, 16'sh7fff, 1'b0);
        send_vertex(16'sh7fff, 16'sh8000, 1'b1);
        // right triangle of side 1.0, hypotenuse rounds down
        send_vertex(16'sh0000, 16'sh0000, 1'b0);
        send_vertex(16'sh0100, 16'sh0000, 1'b0);
        send_vertex(16'sh0000, 16'sh0100, 1'b1);
        // degenerate: three copies of one point
        send_vertex(16'shffff, 16'shffff, 1'b0);
        send_vertex(16'shffff, 16'shffff, 1'b0);
        send_vertex(16'shffff, 16'shffff, 1'b1);
        // full-range triangle, longest possible edge
        send_vertex(16'sh8000, 16'sh8000, 1'b0);
        send_vertex(16'sh7fff, 16'sh8000, 1'b0);
        send_vertex(16'sh7fff, 16'sh7fff, 1'b1);
        // full-range square both ways round: largest area of either sign
        send_square(4, 1'b0);
        send_square(4, 1'b1);
        wait_drained();

        // exactly the vertex limit, count reads back as 256
        tx_burst = 1'b1;
        send_square(MAX_VERTICES_DEF, 1'b0);
        tx_burst = 1'b0;
        // past the limit: extra vertices dropped, tlast on a dropped one
        send_square(MAX_VERTICES_DEF + 3, 1'b1);
        wait_drained();

        // random polygons, mostly short, a long one only while the budget allows
        random_sent = 0;
        while (random_sent < RANDOM_VERTICES) begin
            tx_burst = ($urandom_range(0, 5) == 0);
            rx_burst = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 99);
            if (pick == 0 && random_sent + MAX_VERTICES_DEF + 6 <= RANDOM_VERTICES)
                n = $urandom_range(MAX_VERTICES_DEF - 6, MAX_VERTICES_DEF + 6);
            else if (pick < 10)
                n = $urandom_range(1, 2);
            else
                n = $urandom_range(3, 12);
            spread = coord_spread_t'($urandom_range(0, 2));
            for (int i = 0; i < n; i++)
                send_vertex(rand_coord(spread), rand_coord(spread), i == n - 1);
            if (n > MAX_VERTICES_DEF)
                overlong++;
            random_sent += n;
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
        s_tvalid <= 1'b0;
        tx_burst = 1'b0;

        // let the last results out, bounded, then a short quiet tail
        @(posedge aclk);
        for (int c = 0; c < 20000 && awaited != 0; c++)
            @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("covered %0d vertices in %0d polygons, %0d of them over the %0d-vertex limit",
                 sent_vertices, polygons, overlong, MAX_VERTICES_DEF);
        $display("%0d results compared, %0d mismatches, %0d never arrived",
                 checked, errors, awaited);
        if (errors == 0 && awaited == 0) begin
            $display("PASS polygon_perimeter_and_area");
        end else begin
            $display("FAIL polygon_perimeter_and_area");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("timeout waiting on the block");
        $display("FAIL polygon_perimeter_and_area");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/ppa_pkg.sv
hw/rtl/ppa_edge.sv
hw/rtl/polygon_perimeter_and_area.sv
dv/polygon_checker.sv
dv/testbench.sv
